FILE: src/goih_pkg.sv
package goih_pkg;

    localparam int NBINS = 6;
    localparam int SUM_W = 32;
    localparam int PIX_W = 8;
    localparam int CFG_W = 10;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef logic [SUM_W-1:0] sum_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [2:0]  bin;
        logic [8:0]  mag;
        logic        add;
        logic        first_row;
        logic        row_end;
        logic        frame_end;
    } goih_item_t;

    // exact sector test on |gr|, |gc| (9-bit magnitudes of 8-bit differences) and their signs
    function automatic logic [2:0] pick_bin(input logic signed [9:0] gr,
                                            input logic signed [9:0] gc);
        logic [8:0]         a;
        logic [8:0]         d;
        logic               neg;
        logic signed [11:0] u;
        logic signed [11:0] v;
        logic [21:0]        dd3;
        logic [1:0]         cls;
        logic [2:0]         res;
        a   = gr[9] ? 9'(-gr) : gr[8:0];
        d   = gc[9] ? 9'(-gc) : gc[8:0];
        neg = (gr != 10'sd0) && (gr[9] != gc[9]);
        u   = 12'(2 * {3'b0, d}) - 12'({3'b0, a});
        v   = 12'({3'b0, a}) - 12'(2 * {3'b0, d});
        dd3 = 22'(3) * 22'(d) * 22'(d);
        if (u > 0 && 22'(u * u) > dd3)      cls = 2'd0;
        else if (a <= d)                    cls = 2'd1;
        else if (v > 0 && 22'(v * v) > dd3) cls = 2'd3;
        else                                cls = 2'd2;
        if (gc == 10'sd0)      res = 3'd0;
        else if (cls == 2'd0)  res = 3'd3;
        else if (!neg)         res = (cls == 2'd1) ? 3'd4 : 3'd5;
        else if (cls == 2'd1)  res = 3'd2;
        else if (cls == 2'd2)  res = 3'd1;
        else                   res = 3'd0;
        return res;
    endfunction

endpackage

FILE: src/goih_ram.sv
module goih_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/goih_front.sv
module goih_front import goih_pkg::*; #(
    parameter int MAX_COLUMNS = 512,
    parameter int MAX_ROWS    = 512
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [PIX_W-1:0]         pixel_up,
    input  logic [PIX_W-1:0]         pixel_down,
    input  logic [PIX_W-1:0]         pixel_left,
    input  logic [PIX_W-1:0]         pixel_right,
    input  logic [CFG_W-1:0]         image_width,
    input  logic [CFG_W-1:0]         image_height,
    output logic                     out_valid,
    output goih_item_t               out_item,
    output logic [$clog2(MAX_COLUMNS)-1:0] out_col
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int XW = (CW > RW ? CW : RW) + 2;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [XW-1:0] w, h, c, r;

    // stage 1 registers
    logic               s1_valid_reg;
    logic signed [9:0]  s1_gr_reg, s1_gc_reg;
    logic [16:0]        s1_sq_reg;
    logic               s1_add_reg, s1_first_reg, s1_rend_reg, s1_fend_reg;
    logic [CW-1:0]      s1_col_reg;

    // stage 2: iterative-free root from per-bit restoring steps split over 9 stages
    logic               root_valid [10];
    logic [16:0]        root_rem [10];
    logic [8:0]         root_val [10];
    goih_item_t         root_item [10];
    logic [CW-1:0]      root_col [10];

    logic signed [9:0] gr, gc;
    logic row_end, frame_end;

    always_comb
    begin
        w = (XW'(image_width) < XW'(3)) ? XW'(3) :
            (XW'(image_width) > XW'(MAX_COLUMNS)) ? XW'(MAX_COLUMNS) : XW'(image_width);
        h = (XW'(image_height) < XW'(3)) ? XW'(3) :
            (XW'(image_height) > XW'(MAX_ROWS)) ? XW'(MAX_ROWS) : XW'(image_height);
        c = XW'(col_reg);
        r = XW'(row_reg);
        gr = 10'(signed'({2'b0, pixel_down})) - 10'(signed'({2'b0, pixel_up}));
        gc = 10'(signed'({2'b0, pixel_right})) - 10'(signed'({2'b0, pixel_left}));
        row_end   = (c + XW'(1) >= w);
        frame_end = row_end && (r + XW'(1) >= h);
        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : RW'(r + XW'(1));
        end
        else
        begin
            col_next = CW'(c + XW'(1));
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            if (in_valid)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_gr_reg    <= gr;
            s1_gc_reg    <= gc;
            s1_sq_reg    <= 17'(gr * gr) + 17'(gc * gc);
            s1_add_reg   <= (r >= XW'(1)) && (r + XW'(2) <= h) &&
                            (c >= XW'(1)) && (c + XW'(2) <= w);
            s1_first_reg <= (row_reg == '0);
            s1_rend_reg  <= row_end;
            s1_fend_reg  <= frame_end;
            s1_col_reg   <= col_reg;
        end
    end

    // bin is decided here; magnitude via nine one-bit root steps
    always_comb
    begin
        root_valid[0]           = s1_valid_reg;
        root_rem[0]             = s1_sq_reg;
        root_val[0]             = '0;
        root_item[0].bin        = pick_bin(s1_gr_reg, s1_gc_reg);
        root_item[0].mag        = '0;
        root_item[0].add        = s1_add_reg;
        root_item[0].first_row  = s1_first_reg;
        root_item[0].row_end    = s1_rend_reg;
        root_item[0].frame_end  = s1_fend_reg;
        root_col[0]             = s1_col_reg;
    end

    for (genvar i = 0; i < 9; i++)
    begin : g_root
        localparam int B = 8 - i;
        logic [17:0] trial;
        logic        take;
        logic        v_reg;
        logic [16:0] rem_reg;
        logic [8:0]  val_reg;
        goih_item_t  item_reg;
        logic [CW-1:0] col_q;

        // try setting bit B: (val + 2^B)^2 <= sq  ->  rem >= 2*val*2^B + 4^B
        assign trial = (18'(root_val[i]) << (B + 1)) + (18'(1) << (2 * B));
        assign take  = (18'(root_rem[i]) >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else
            begin
                v_reg <= root_valid[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg  <= take ? 17'(18'(root_rem[i]) - trial) : root_rem[i];
            val_reg  <= take ? (root_val[i] | (9'(1) << B)) : root_val[i];
            item_reg <= root_item[i];
            col_q    <= root_col[i];
        end

        assign root_valid[i+1] = v_reg;
        assign root_rem[i+1]   = rem_reg;
        assign root_val[i+1]   = val_reg;
        assign root_item[i+1]  = item_reg;
        assign root_col[i+1]   = col_q;
    end

    always_comb
    begin
        out_valid     = root_valid[9];
        out_item      = root_item[9];
        out_item.mag  = root_val[9];
        out_col       = root_col[9];
    end

endmodule

FILE: src/goih_back.sv
module goih_back import goih_pkg::*; #(
    parameter int MAX_COLUMNS = 512
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  goih_item_t                     in_item,
    input  logic [$clog2(MAX_COLUMNS)-1:0] in_col,
    output logic                           res_valid,
    output logic [NBINS*SUM_W-1:0]         res_sums,
    output logic                           res_row_end,
    output logic                           res_frame_end
);

    localparam int CW = $clog2(MAX_COLUMNS);

    // stage A: issue read, update row sums
    sum_t       run_reg [NBINS];
    logic       a_valid_reg;
    goih_item_t a_item_reg;
    logic [CW-1:0] a_col_reg;
    logic [NBINS*SUM_W-1:0] a_run_reg;
    logic [NBINS*SUM_W-1:0] rd_data;
    logic [NBINS*SUM_W-1:0] wr_data;
    logic [NBINS*SUM_W-1:0] run_cur;

    always_comb
    begin
        for (int k = 0; k < NBINS; k++)
        begin
            run_cur[k*SUM_W +: SUM_W] = run_reg[k] +
                ((in_item.add && in_item.bin == 3'(k)) ? SUM_W'(in_item.mag) : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NBINS; k++)
            begin
                run_reg[k] <= '0;
            end
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            if (in_valid)
            begin
                for (int k = 0; k < NBINS; k++)
                begin
                    run_reg[k] <= in_item.row_end ? '0 : run_cur[k*SUM_W +: SUM_W];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_item_reg <= in_item;
        a_col_reg  <= in_col;
        a_run_reg  <= run_cur;
    end

    // same column cannot be read-after-written within two items since width >= 3
    goih_ram #(.WIDTH(NBINS*SUM_W), .DEPTH(MAX_COLUMNS)) u_prev_row (
        .clk   (clk),
        .we    (a_valid_reg),
        .waddr (a_col_reg),
        .wdata (wr_data),
        .raddr (in_col),
        .rdata (rd_data)
    );

    always_comb
    begin
        for (int k = 0; k < NBINS; k++)
        begin
            wr_data[k*SUM_W +: SUM_W] = a_run_reg[k*SUM_W +: SUM_W] +
                (a_item_reg.first_row ? '0 : rd_data[k*SUM_W +: SUM_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid <= 1'b0;
        end
        else
        begin
            res_valid <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_sums      <= wr_data;
        res_row_end   <= a_item_reg.row_end;
        res_frame_end <= a_item_reg.frame_end;
    end

endmodule

FILE: src/goih_fifo.sv
module goih_fifo import goih_pkg::*; #(
    parameter int WIDTH = 194,
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= AW'(wp_reg + AW'(1));
            end
            if (pop && !empty)
            begin
                rp_reg <= AW'(rp_reg + AW'(1));
            end
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - ((pop && !empty) ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= wdata;
        end
    end

    assign rdata = mem[rp_reg];
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;

endmodule

FILE: src/gradient_orientation_integral_histogram_unit.sv
// Requests pass front stage 1, the root steps, back stage A and result regs to the output queue.
// Throughput: one request per cycle while full is low; the front root pipeline and the row-memory
// read-modify-write stage each take one request per clock.
// full rises while the output queue could not absorb all requests in flight.
// Reset (rst_n low, asynchronous) clears counters, row sums and queues; width and height go to 512.
module gradient_orientation_integral_histogram_unit import goih_pkg::*; #(
    parameter int MAX_COLUMNS = 512,
    parameter int MAX_ROWS    = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [PIX_W-1:0]   pixel_up,
    input  logic [PIX_W-1:0]   pixel_down,
    input  logic [PIX_W-1:0]   pixel_left,
    input  logic [PIX_W-1:0]   pixel_right,
    output logic               empty,
    input  logic               pop,
    output logic [SUM_W-1:0]   bin0_sum,
    output logic [SUM_W-1:0]   bin1_sum,
    output logic [SUM_W-1:0]   bin2_sum,
    output logic [SUM_W-1:0]   bin3_sum,
    output logic [SUM_W-1:0]   bin4_sum,
    output logic [SUM_W-1:0]   bin5_sum,
    output logic               row_end,
    output logic               frame_end,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int CW     = $clog2(MAX_COLUMNS);
    localparam int QDEPTH = 32;
    localparam int QW     = NBINS*SUM_W + 2;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic             accept;
    logic             f_valid, b_valid;
    goih_item_t       f_item;
    logic [CW-1:0]    f_col;
    logic [NBINS*SUM_W-1:0] b_sums;
    logic             b_rend, b_fend;
    logic [QW-1:0]    q_out;
    logic [$clog2(QDEPTH+1)-1:0] q_count;
    logic [4:0]       flight_reg;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(512);
            height_reg <= CFG_W'(512);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // requests in the pipeline, reserved queue space
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= '0;
        end
        else
        begin
            flight_reg <= flight_reg + (accept ? 5'd1 : 5'd0) - (b_valid ? 5'd1 : 5'd0);
        end
    end

    assign full = (6'(q_count) + 6'(flight_reg) >= 6'(QDEPTH));

    goih_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .pixel_up     (pixel_up),
        .pixel_down   (pixel_down),
        .pixel_left   (pixel_left),
        .pixel_right  (pixel_right),
        .image_width  (width_reg),
        .image_height (height_reg),
        .out_valid    (f_valid),
        .out_item     (f_item),
        .out_col      (f_col)
    );

    goih_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (f_valid),
        .in_item       (f_item),
        .in_col        (f_col),
        .res_valid     (b_valid),
        .res_sums      (b_sums),
        .res_row_end   (b_rend),
        .res_frame_end (b_fend)
    );

    goih_fifo #(.WIDTH(QW), .DEPTH(QDEPTH)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (b_valid),
        .wdata ({b_fend, b_rend, b_sums}),
        .pop   (pop),
        .rdata (q_out),
        .empty (empty),
        .count (q_count)
    );

    assign bin0_sum  = q_out[0*SUM_W +: SUM_W];
    assign bin1_sum  = q_out[1*SUM_W +: SUM_W];
    assign bin2_sum  = q_out[2*SUM_W +: SUM_W];
    assign bin3_sum  = q_out[3*SUM_W +: SUM_W];
    assign bin4_sum  = q_out[4*SUM_W +: SUM_W];
    assign bin5_sum  = q_out[5*SUM_W +: SUM_W];
    assign row_end   = q_out[NBINS*SUM_W];
    assign frame_end = q_out[NBINS*SUM_W + 1];

endmodule

FILE: dv/gradient_orientation_integral_histogram_unit_tb.sv
`timescale 1ns / 100ps

module gradient_orientation_integral_histogram_unit_tb;
    import goih_pkg::*;

    localparam int MAX_COLS  = 512;
    localparam int MAX_ROWS_ = 512;
    localparam int LIMIT     = 600000;
    localparam int DRAIN     = 20;   // extra idle wait after the last expected result is checked

    typedef struct {
        sum_t sums [NBINS];
        logic row_end;
        logic frame_end;
    } hist_result_t;

    class hist_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned col;
        int unsigned row;
        sum_t row_sums [NBINS];
        sum_t above_row [MAX_COLS][NBINS];
        hist_result_t expected_q [$];
        int errors;
        int checked;
        int frames;

        function new();
            width_reg  = 512;
            height_reg = 512;
            col = 0;
            row = 0;
            errors = 0;
            checked = 0;
            frames = 0;
            foreach (row_sums[k]) row_sums[k] = '0;
        endfunction

        function void set_reg(reg_index_t idx, logic [CFG_W-1:0] val);
            if (idx == REG_IMAGE_WIDTH) width_reg = val;
            else height_reg = val;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v < 3) return 3;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned isqrt(int unsigned v);
            int unsigned res;
            res = 0;
            while ((res + 1) * (res + 1) <= v) res++;
            return res;
        endfunction

        // exact sector test on the slope gr/gc
        function int orient_bin(int gr, int gc);
            int a;
            int d;
            int u;
            int v;
            bit neg;
            int cls;
            if (gc == 0) return 0;
            a = gr < 0 ? -gr : gr;
            d = gc < 0 ? -gc : gc;
            neg = (gr != 0) && ((gr < 0) != (gc < 0));
            u = 2 * d - a;
            v = a - 2 * d;
            if (u > 0 && u * u > 3 * d * d) cls = 0;
            else if (a <= d) cls = 1;
            else if (v > 0 && v * v > 3 * d * d) cls = 3;
            else cls = 2;
            if (cls == 0) return 3;
            if (!neg) return cls == 1 ? 4 : 5;
            return cls == 1 ? 2 : (cls == 2 ? 1 : 0);
        endfunction

        function void note_pixel(logic [7:0] up, logic [7:0] down,
                                 logic [7:0] left, logic [7:0] right);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int gr;
            int gc;
            hist_result_t res;
            w = clamp(width_reg, MAX_COLS);
            h = clamp(height_reg, MAX_ROWS_);
            c = col;
            if (c >= MAX_COLS) c = MAX_COLS - 1;
            if (row >= 1 && row + 2 <= h && c >= 1 && c + 2 <= w) begin
                gr = int'(down) - int'(up);
                gc = int'(right) - int'(left);
                row_sums[orient_bin(gr, gc)] += sum_t'(isqrt(gr * gr + gc * gc));
            end
            for (int k = 0; k < NBINS; k++) begin
                res.sums[k] = (row == 0 ? sum_t'(0) : above_row[c][k]) + row_sums[k];
                above_row[c][k] = res.sums[k];
            end
            res.row_end   = (c + 1 >= w);
            res.frame_end = res.row_end && (row + 1 >= h);
            expected_q.push_back(res);
            if (res.row_end) begin
                col = 0;
                foreach (row_sums[k]) row_sums[k] = '0;
                if (res.frame_end) begin
                    row = 0;
                    frames++;
                end
                else row = row + 1;
            end
            else col = c + 1;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch at result %0d: %s got 0x%08h expected 0x%08h",
                     checked, what, got, want);
        endtask

        task check_result(hist_result_t got);
            hist_result_t want;
            if (expected_q.size() == 0) begin
                report("unexpected result", 0, 0);
                return;
            end
            want = expected_q.pop_front();
            for (int k = 0; k < NBINS; k++)
                if (got.sums[k] !== want.sums[k])
                    report($sformatf("bin%0d_sum", k), got.sums[k], want.sums[k]);
            if (got.row_end !== want.row_end)
                report("row_end", 32'(got.row_end), 32'(want.row_end));
            if (got.frame_end !== want.frame_end)
                report("frame_end", 32'(got.frame_end), 32'(want.frame_end));
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [PIX_W-1:0] pixel_up, pixel_down, pixel_left, pixel_right;
    logic empty;
    logic pop;
    logic [SUM_W-1:0] bin0_sum, bin1_sum, bin2_sum, bin3_sum, bin4_sum, bin5_sum;
    logic row_end, frame_end;
    logic cfg_valid;
    logic cfg_ready;
    logic [0:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    hist_scoreboard sb;
    int cycles;
    int burst_left;
    int pixels_sent;

    gradient_orientation_integral_histogram_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel_up    (pixel_up),
        .pixel_down  (pixel_down),
        .pixel_left  (pixel_left),
        .pixel_right (pixel_right),
        .empty       (empty),
        .pop         (pop),
        .bin0_sum    (bin0_sum),
        .bin1_sum    (bin1_sum),
        .bin2_sum    (bin2_sum),
        .bin3_sum    (bin3_sum),
        .bin4_sum    (bin4_sum),
        .bin5_sum    (bin5_sum),
        .row_end     (row_end),
        .frame_end   (frame_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL gradient_orientation_integral_histogram_unit");
            $finish;
        end
    end

    // result side: stall pattern changes mode every so often
    initial
    begin
        hist_result_t got;
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                got.sums[0] = bin0_sum;
                got.sums[1] = bin1_sum;
                got.sums[2] = bin2_sum;
                got.sums[3] = bin3_sum;
                got.sums[4] = bin4_sum;
                got.sums[5] = bin5_sum;
                got.row_end = row_end;
                got.frame_end = frame_end;
                sb.check_result(got);
            end
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
                0: pop = 1'b1;
                1: pop = ($urandom_range(0, 3) != 0);
                2: pop = ($urandom_range(0, 3) == 0);
                default: pop = (cycles % 16) < 5;
            endcase
        end
    end

    task automatic send_pixel(logic [7:0] up, logic [7:0] down,
                              logic [7:0] left, logic [7:0] right);
        @(negedge clk);
        pixel_up = up;
        pixel_down = down;
        pixel_left = left;
        pixel_right = right;
        push = 1'b1;
        do @(posedge clk); while (full);
        sb.note_pixel(up, down, left, right);
        pixels_sent++;
        if (burst_left > 0) burst_left--;
        else
        begin
            @(negedge clk);
            push = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                      : $urandom_range(0, 12);
        end
    endtask

    task automatic send_random_pixel();
        logic [7:0] base;
        if ($urandom_range(0, 2) == 0)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else
        begin
            // small differences reach the narrow sectors more often
            base = 8'($urandom_range(20, 235));
            send_pixel(base + 8'($urandom_range(0, 40)) - 8'd20,
                       base + 8'($urandom_range(0, 40)) - 8'd20,
                       base + 8'($urandom_range(0, 40)) - 8'd20,
                       base + 8'($urandom_range(0, 40)) - 8'd20);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        push = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic finish_frame();
        do send_random_pixel(); while (sb.col != 0 || sb.row != 0);
    endtask

    logic [7:0] directed [20][4] = '{
        '{0, 0, 0, 0},       '{255, 255, 255, 255}, '{0, 255, 128, 128},
        '{255, 0, 128, 128}, '{0, 0, 0, 255},       '{0, 0, 255, 0},
        '{0, 255, 0, 255},   '{255, 0, 0, 255},     '{0, 255, 255, 0},
        '{255, 0, 255, 0},   '{0, 26, 0, 100},      '{0, 27, 0, 100},
        '{26, 0, 0, 100},    '{27, 0, 0, 100},      '{0, 186, 0, 50},
        '{186, 0, 0, 50},    '{187, 0, 0, 50},      '{0, 187, 0, 50},
        '{0, 1, 0, 1},       '{0, 1, 1, 0}
    };

    initial
    begin
        sb = new();
        cycles = 0;
        burst_left = 0;
        pixels_sent = 0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        pixel_up = '0;
        pixel_down = '0;
        pixel_left = '0;
        pixel_right = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 3x3 frames: the center pixel is the only one that counts
        set_size(3, 3);
        foreach (directed[k])
            repeat (9) send_pixel(directed[k][0], directed[k][1],
                                  directed[k][2], directed[k][3]);

        // out-of-range sizes clamp to 3 and to the maximum
        set_size(0, 2);
        finish_frame();
        // one full row at the clamped maximum width, then shrink to finish
        set_size(1023, 1);
        repeat (MAX_COLS) send_random_pixel();
        set_size(3, 3);
        finish_frame();
        // a few rows at the clamped maximum height, then cut the frame short
        set_size(3, 1023);
        repeat (9) send_random_pixel();
        set_size(3, 3);
        finish_frame();

        // size lowered in the middle of a frame
        set_size(20, 10);
        repeat (45) send_random_pixel();
        set_size(4, 10);
        repeat (9) send_random_pixel();
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 3);
        finish_frame();

        while (pixels_sent < 800)
        begin
            set_size(10'($urandom_range(3, 10)), 10'($urandom_range(3, 6)));
            finish_frame();
        end

        wait_idle();
        $display("%0d pixels in %0d frames checked over %0d results, %0d mismatches",
                 pixels_sent, sb.frames, sb.checked, sb.errors);
        $display("covered clamped sizes, mid-frame size drops and all six orientation bins");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS gradient_orientation_integral_histogram_unit");
        else
            $display("FAIL gradient_orientation_integral_histogram_unit");
        $finish;
    end

endmodule

FILE: gradient_orientation_integral_histogram_unit.f
src/goih_pkg.sv
src/goih_ram.sv
src/goih_front.sv
src/goih_back.sv
src/goih_fifo.sv
src/gradient_orientation_integral_histogram_unit.sv
dv/gradient_orientation_integral_histogram_unit_tb.sv
